### rtl/aifp_pkg.sv
// Shared types and constants for the IMU attitude frame parser.
// Used by aifp_parser, aifp_status and imu_attitude_frame_parser_top.
package aifp_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h53;
  localparam logic [7:0] HDR_SUM    = 8'(HDR_FIRST + HDR_SECOND);

  // Data bytes follow the headers at positions 0 to 8; position 8 is the sum byte.
  localparam int unsigned POS_WIDTH   = 4;
  localparam logic [POS_WIDTH-1:0] POS_SUM_BYTE = 4'd8;
  // Only the six angle bytes are kept; the next two bytes go only into the running sum.
  localparam int unsigned STORE_DEPTH = 6;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_YAW_ZERO = 2'd1,
    OP_YAW_SET  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FRAME   = 2'd1,
    EV_SUM_ERR = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  // Completion report from the parser to the status registers.
  typedef struct packed {
    logic        done;
    logic        sum_ok;
    logic [15:0] roll_word;
    logic [15:0] pitch_word;
    logic [15:0] yaw_word;
  } frame_evt_t;

  // A raw word above 32768 stands for raw minus 65536.
  function automatic logic signed [16:0] word_to_angle(input logic [15:0] raw);
    word_to_angle = {(raw > 16'd32768), raw};
  endfunction

endpackage

### rtl/aifp_parser.sv
// Header hunt, byte collection and running checksum for one frame.
// Depends on aifp_pkg.
module aifp_parser import aifp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output frame_evt_t           evt,
  output logic [POS_WIDTH-1:0] position
);

  phase_t               phase, phase_next;
  logic [POS_WIDTH-1:0] pos, pos_next;
  logic [7:0]           sum, sum_next;
  logic [7:0]           store [STORE_DEPTH];
  logic                 store_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      pos   <= '0;
      sum   <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      sum   <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[pos[STORE_IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    sum_next       = sum;
    store_we       = 1'b0;
    evt.done       = 1'b0;
    evt.sum_ok     = (sum == rx_byte);
    evt.roll_word  = {store[1], store[0]};
    evt.pitch_word = {store[3], store[2]};
    evt.yaw_word   = {store[5], store[4]};
    unique case (phase)
      PH_HUNT1: begin
        if (step && rx_byte == HDR_FIRST) begin
          phase_next = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (step) begin
          if (rx_byte == HDR_SECOND) begin
            phase_next = PH_DATA;
            pos_next   = '0;
            sum_next   = HDR_SUM;
          end else begin
            phase_next = PH_HUNT1;
          end
        end
      end
      PH_DATA: begin
        if (step) begin
          if (pos >= POS_SUM_BYTE) begin
            evt.done   = 1'b1;
            phase_next = PH_HUNT1;
            pos_next   = '0;
          end else begin
            store_we = (pos < POS_WIDTH'(STORE_DEPTH));
            sum_next = sum + rx_byte;
            pos_next = pos + 1'b1;
          end
        end
      end
      default: begin
        if (step) begin
          phase_next = PH_HUNT1;
          pos_next   = '0;
        end
      end
    endcase
  end

  assign position = pos;

endmodule

### rtl/aifp_status.sv
// Angle, yaw offset and counter registers; they double as the result register.
// Depends on aifp_pkg.
module aifp_status import aifp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [1:0]              opcode,
  input  logic signed [16:0]      target_yaw,
  input  frame_evt_t              evt,
  output logic [1:0]              event_res,
  output logic signed [16:0]      roll_angle,
  output logic signed [16:0]      pitch_angle,
  output logic signed [17:0]      yaw_angle,
  output logic [15:0]             yaw_word,
  output logic [COUNT_WIDTH-1:0]  byte_cnt,
  output logic [COUNT_WIDTH-1:0]  frame_cnt,
  output logic [COUNT_WIDTH-1:0]  sum_err_cnt
);

  logic signed [16:0] roll_value, pitch_value, yaw_value;
  logic signed [16:0] yaw_new;
  logic signed [17:0] yaw_offset;
  logic signed [17:0] yaw_rel;
  logic [1:0]         event_q;
  logic               frame_ok;
  logic               frame_bad;

  assign yaw_new   = word_to_angle(evt.yaw_word);
  assign frame_ok  = evt.done && evt.sum_ok;
  assign frame_bad = evt.done && !evt.sum_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_q     <= EV_NONE;
      roll_value  <= '0;
      pitch_value <= '0;
      yaw_value   <= '0;
      yaw_word    <= '0;
      yaw_offset  <= '0;
      yaw_rel     <= '0;
      byte_cnt    <= '0;
      frame_cnt   <= '0;
      sum_err_cnt <= '0;
    end else if (advance) begin
      event_q <= EV_NONE;
      unique case (opcode)
        OP_BYTE: begin
          byte_cnt <= byte_cnt + 1'b1;
          if (frame_ok) begin
            event_q     <= EV_FRAME;
            roll_value  <= word_to_angle(evt.roll_word);
            pitch_value <= word_to_angle(evt.pitch_word);
            yaw_value   <= yaw_new;
            yaw_word    <= evt.yaw_word;
            yaw_rel     <= 18'(yaw_new) - yaw_offset;
            frame_cnt   <= frame_cnt + 1'b1;
          end else if (frame_bad) begin
            event_q     <= EV_SUM_ERR;
            sum_err_cnt <= sum_err_cnt + 1'b1;
          end
        end
        OP_YAW_ZERO: begin
          yaw_offset <= 18'(yaw_value);
          yaw_rel    <= '0;
        end
        OP_YAW_SET: begin
          yaw_offset <= 18'(yaw_value) - 18'(target_yaw);
          yaw_rel    <= 18'(target_yaw);
        end
        default: begin
        end
      endcase
    end
  end

  assign event_res   = event_q;
  assign roll_angle  = roll_value;
  assign pitch_angle = pitch_value;
  assign yaw_angle   = yaw_rel;

endmodule

### rtl/imu_attitude_frame_parser_top.sv
// Top level of the IMU attitude frame parser: input register, handshake, assertions.
// Depends on aifp_pkg, aifp_parser and aifp_status.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    opcode, rx_byte, target_yaw
//   out      output     out_valid / out_ready  event_res, angles, yaw_word, counts
//
// One request is accepted per cycle while the result side does not stall; each gives
// exactly one result, held first in the input register, then in the status registers that form the result.
// The checksum is kept as a running 8-bit sum, so the last byte needs one compare.
// Reset clears the parser, angles, offset, counters and both valid flags.
// A stalled result holds everything; the input register keeps taking a request
// in the same cycle that the waiting result is taken.
module imu_attitude_frame_parser_top import aifp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [7:0]         rx_byte,
  input  logic signed [16:0] target_yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_res,
  output logic signed [16:0] roll_angle,
  output logic signed [16:0] pitch_angle,
  output logic signed [17:0] yaw_angle,
  output logic [15:0]        yaw_word,
  output logic [31:0]        byte_count,
  output logic [31:0]        good_frame_count,
  output logic [31:0]        sum_error_count
);

  logic                   s1_valid;
  logic [1:0]             s1_opcode;
  logic [7:0]             s1_byte;
  logic signed [16:0]     s1_target;
  logic                   advance;
  logic                   out_valid_q;
  frame_evt_t             evt;
  logic [POS_WIDTH-1:0]   position;
  logic [COUNT_WIDTH-1:0] byte_cnt, frame_cnt, sum_err_cnt;

  assign advance  = s1_valid && (!out_valid_q || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_byte   <= rx_byte;
      s1_target <= target_yaw;
    end
  end

  aifp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance && s1_opcode == OP_BYTE),
    .rx_byte  (s1_byte),
    .evt      (evt),
    .position (position)
  );

  aifp_status #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_status (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .opcode      (s1_opcode),
    .target_yaw  (s1_target),
    .evt         (evt),
    .event_res   (event_res),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .yaw_word    (yaw_word),
    .byte_cnt    (byte_cnt),
    .frame_cnt   (frame_cnt),
    .sum_err_cnt (sum_err_cnt)
  );

  assign out_valid        = out_valid_q;
  assign byte_count       = 32'(byte_cnt);
  assign good_frame_count = 32'(frame_cnt);
  assign sum_error_count  = 32'(sum_err_cnt);

`ifndef ASSERT_OFF
  // A held request is not dropped while the result side stalls.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("held request lost while stalled");

  // The byte count moves only for a received byte.
  assert property (@(posedge clk) disable iff (rst)
    (!(advance && s1_opcode == OP_BYTE)) |=> $stable(byte_cnt))
    else $error("byte count changed without a received byte");

  // The parser never runs past the sum byte.
  assert property (@(posedge clk) disable iff (rst)
    position <= POS_SUM_BYTE)
    else $error("frame position beyond sum byte");

  // A frame event reaches the result only with a matching frame count step.
  assert property (@(posedge clk) disable iff (rst)
    (advance && evt.done && evt.sum_ok && s1_opcode == OP_BYTE)
      |=> (frame_cnt == $past(frame_cnt) + 1'b1) && event_res == EV_FRAME)
    else $error("accepted frame not counted");
`endif

endmodule
